// File: rtl/core/rtfb_pkg.sv
// Shared types, constants and a blend function for the rgb444 text fade blend.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtfb_pkg;

  localparam int unsigned SizeBits  = 11;
  localparam int unsigned StepBits  = 8;
  localparam int unsigned PixBits   = 12;
  localparam int unsigned ShadeBits = 8;
  localparam int unsigned NibBits   = 4;
  localparam int unsigned RampBits  = 16;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;

  localparam logic [SizeBits-1:0] WidthReset  = 11'd640;
  localparam logic [SizeBits-1:0] HeightReset = 11'd480;
  localparam logic [StepBits-1:0] StepReset   = 8'd0;
  localparam logic [PixBits-1:0]  ColorReset  = 12'd0;

  localparam logic [NibBits-1:0] NibMax = 4'hF;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STEP   = 2'd2,
    REG_COLOR  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SizeBits-1:0] width;
    logic [SizeBits-1:0] height;
    logic [StepBits-1:0] step;
    logic [PixBits-1:0]  color;
  } cfg_t;

  typedef struct packed {
    logic [RampBits-1:0] rows_left;
    logic                row_end;
    logic                region_end;
  } pos_t;

  typedef struct packed {
    logic               we;
    logic [NibBits-1:0] alpha;
  } ramp_t;

  // (text*(15-alpha) + dest*alpha)/15, clamped; the sum stays below 226,
  // so the divide is a multiply by 137/2048
  function automatic logic [NibBits-1:0] mix_nibble(
    input logic [NibBits-1:0] text,
    input logic [NibBits-1:0] dest,
    input logic [NibBits-1:0] alpha
  );
    logic [7:0]  sum;
    logic [15:0] prod;
    logic [4:0]  quo;
    sum  = 8'(text) * 8'(NibMax - alpha) + 8'(dest) * 8'(alpha);
    prod = 16'(sum) * 16'd137;
    quo  = prod[15:11];
    mix_nibble = (quo > 5'(NibMax)) ? NibMax : quo[NibBits-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtfb_regs.sv
// Configuration register file behind the APB-style port.
// Depends on rtfb_pkg.
`default_nettype none

module rtfb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rtfb_pkg::AddrBits-1:0] paddr,
  input  wire logic [rtfb_pkg::DataBits-1:0] pwdata,
  output logic      [rtfb_pkg::DataBits-1:0] prdata,
  output logic                               pready,
  output rtfb_pkg::cfg_t                     cfg_o
);
  import rtfb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  cfg_d.width  = pwdata[SizeBits-1:0];
        REG_HEIGHT: cfg_d.height = pwdata[SizeBits-1:0];
        REG_STEP:   cfg_d.step   = pwdata[StepBits-1:0];
        REG_COLOR:  cfg_d.color  = pwdata[PixBits-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = DataBits'(cfg_q.width);
      REG_HEIGHT: prdata = DataBits'(cfg_q.height);
      REG_STEP:   prdata = DataBits'(cfg_q.step);
      REG_COLOR:  prdata = DataBits'(cfg_q.color);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WidthReset;
      cfg_q.height <= HeightReset;
      cfg_q.step   <= StepReset;
      cfg_q.color  <= ColorReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/rtfb_walker.sv
// Column and row counters that walk the region in raster order.
// Depends on rtfb_pkg.
`default_nettype none

module rtfb_walker #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire rtfb_pkg::cfg_t cfg_i,
  output rtfb_pkg::pos_t      pos_o
);
  import rtfb_pkg::*;

  localparam int unsigned CmpBits =
    ((COORD_BITS > SizeBits) ? COORD_BITS : SizeBits) + 1;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic                  row_end, region_end;

  // a counter at all ones ends its row or region regardless of the size
  assign row_end = ((CmpBits'(col_q) + CmpBits'(1)) >= CmpBits'(cfg_i.width)) ||
                   (col_q == '1);
  assign region_end = row_end &&
                      (((CmpBits'(row_q) + CmpBits'(1)) >= CmpBits'(cfg_i.height)) ||
                       (row_q == '1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = region_end ? '0 : row_q + COORD_BITS'(1);
      end else begin
        col_d = col_q + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.rows_left  = RampBits'(cfg_i.height) - RampBits'(row_q);
  assign pos_o.row_end    = row_end;
  assign pos_o.region_end = region_end;

endmodule

`default_nettype wire

// File: rtl/core/rtfb_ramp.sv
// Alpha from the coverage byte plus the vertical fade ramp.
// Depends on rtfb_pkg.
`default_nettype none

module rtfb_ramp (
  input  wire logic [rtfb_pkg::ShadeBits-1:0] shade_i,
  input  wire logic [rtfb_pkg::RampBits-1:0]  rows_left_i,
  input  wire logic [rtfb_pkg::StepBits-1:0]  step_i,
  output rtfb_pkg::ramp_t                     ramp_o
);
  import rtfb_pkg::*;

  logic [StepBits+RampBits-1:0] prod;
  logic [RampBits-1:0]          sum;

  assign prod = (StepBits+RampBits)'(step_i) * (StepBits+RampBits)'(rows_left_i);
  assign sum  = RampBits'(shade_i) + prod[RampBits-1:0];

  // alpha = sum >> 4; it fits a nibble only when the top byte is clear
  assign ramp_o.we    = (sum[RampBits-1:8] == '0);
  assign ramp_o.alpha = sum[7:4];

endmodule

`default_nettype wire

// File: rtl/core/rtfb_mix.sv
// Per-channel blend of the text colour over the destination pixel.
// Depends on rtfb_pkg.
`default_nettype none

module rtfb_mix (
  input  wire logic [rtfb_pkg::PixBits-1:0] text_i,
  input  wire logic [rtfb_pkg::PixBits-1:0] dest_i,
  input  wire rtfb_pkg::ramp_t              ramp_i,
  output logic      [rtfb_pkg::PixBits-1:0] pix_o
);
  import rtfb_pkg::*;

  logic [PixBits-1:0] mixed;

  for (genvar c = 0; c < PixBits / NibBits; c++) begin : g_chan
    assign mixed[c*NibBits +: NibBits] =
      mix_nibble(text_i[c*NibBits +: NibBits], dest_i[c*NibBits +: NibBits],
                 ramp_i.alpha);
  end

  // destination passes through when the pixel is not written
  assign pix_o = ramp_i.we ? mixed : dest_i;

endmodule

`default_nettype wire

// File: rtl/core/rgb444_text_fade_blend.sv
// Top level of the rgb444 text fade blend: stream ports, config port, pipeline.
// Depends on rtfb_pkg, rtfb_regs, rtfb_walker, rtfb_ramp and rtfb_mix.
`default_nettype none

// Blends a text colour over a 4:4:4 pixel stream walked in raster order over
// a region_width by region_height region. One pixel is taken per clock while
// s_axis_tready is high. Three registers carry it (input register, fade ramp
// multiply into the alpha register, channel mix into the output register), in
// that order. Every stage holds its own valid bit and stalls only when the stage
// after it is full, so a result waiting on the output holds back input only
// once the two stages before it are full as well.
// Configuration must be written through the APB-style port only while the
// stream is idle; the block itself does not enforce this. Addresses 0, 4, 8
// and 12 hold width, height, fade step and text colour.
module rgb444_text_fade_blend #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rtfb_pkg::AddrBits-1:0] paddr,
  input  wire logic [rtfb_pkg::DataBits-1:0] pwdata,
  output logic      [rtfb_pkg::DataBits-1:0] prdata,
  output logic                               pready,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // source_shade, dest_pixel, pad
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [15:0]                   m_axis_tdata,  // blended_pixel, pad
  output logic                               m_axis_tlast,  // row_end
  output logic      [1:0]                    m_axis_tuser   // write_enable, region_end
);
  import rtfb_pkg::*;

  cfg_t  cfg;
  pos_t  pos;
  ramp_t ramp;
  logic  in_xfer;
  logic  rdy1, rdy2, rdy3;

  // stage 1: input register
  logic                 v1_q;
  logic [ShadeBits-1:0] shade1_q;
  logic [PixBits-1:0]   dest1_q;
  logic [RampBits-1:0]  rows1_q;
  logic                 rend1_q, gend1_q;
  // stage 2: alpha register
  logic                 v2_q;
  ramp_t                ramp2_q;
  logic [PixBits-1:0]   dest2_q;
  logic                 rend2_q, gend2_q;
  // stage 3: output register
  logic                 v3_q;
  logic                 we3_q;
  logic [PixBits-1:0]   pix3_q, pix;
  logic                 rend3_q, gend3_q;

  rtfb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_xfer       = s_axis_tvalid && rdy1;

  rtfb_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .cfg_i  (cfg),
    .pos_o  (pos)
  );

  rtfb_ramp u_ramp (
    .shade_i     (shade1_q),
    .rows_left_i (rows1_q),
    .step_i      (cfg.step),
    .ramp_o      (ramp)
  );

  rtfb_mix u_mix (
    .text_i (cfg.color),
    .dest_i (dest2_q),
    .ramp_i (ramp2_q),
    .pix_o  (pix)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      shade1_q <= s_axis_tdata[ShadeBits-1:0];
      dest1_q  <= s_axis_tdata[ShadeBits +: PixBits];
      rows1_q  <= pos.rows_left;
      rend1_q  <= pos.row_end;
      gend1_q  <= pos.region_end;
    end
    if (v1_q && rdy2) begin
      ramp2_q <= ramp;
      dest2_q <= dest1_q;
      rend2_q <= rend1_q;
      gend2_q <= gend1_q;
    end
    if (v2_q && rdy3) begin
      we3_q   <= ramp2_q.we;
      pix3_q  <= pix;
      rend3_q <= rend2_q;
      gend3_q <= gend2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {4'd0, pix3_q};
  assign m_axis_tlast  = rend3_q;
  assign m_axis_tuser  = {gend3_q, we3_q};

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for rgb444_text_fade_blend: directed and random pixel streams
// with a raster-walk and blend predictor, checked field by field on every result transfer.
// Depends on rtfb_pkg and the rgb444_text_fade_blend RTL.
`timescale 1ns / 1ps

module tb_top;
  import rtfb_pkg::*;

  localparam int unsigned CoordBits  = 10;
  localparam int unsigned PipeDepth  = 3;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [CoordBits-1:0] CoordLast = '1;

  typedef struct packed {
    logic               we;
    logic [PixBits-1:0] pix;
    logic               row_end;
    logic               region_end;
  } blend_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrBits-1:0] paddr         = '0;
  logic [DataBits-1:0] pwdata        = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // source_shade, dest_pixel, pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [15:0]         m_axis_tdata;        // blended_pixel, pad
  logic                m_axis_tlast;        // row_end
  logic [1:0]          m_axis_tuser;        // write_enable, region_end

  // predictor copy of the registers and the raster position
  logic [SizeBits-1:0]  exp_width;
  logic [SizeBits-1:0]  exp_height;
  logic [StepBits-1:0]  exp_step;
  logic [PixBits-1:0]   exp_color;
  logic [CoordBits-1:0] col_pos;
  logic [CoordBits-1:0] row_pos;

  blend_res_t  expected_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;

  rgb444_text_fade_blend #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [NibBits-1:0] shade_channel(
    input logic [NibBits-1:0] text,
    input logic [NibBits-1:0] dest,
    input logic [NibBits-1:0] alpha
  );
    int unsigned v;
    v = (int'(text) * (15 - int'(alpha)) + int'(dest) * int'(alpha)) / 15;
    return (v > 15) ? 4'hF : v[NibBits-1:0];
  endfunction

  // expected result of one pixel; advances the raster position
  function automatic blend_res_t fade_blend_pixel(
    input logic [ShadeBits-1:0] shade,
    input logic [PixBits-1:0]   dest
  );
    logic [15:0] rows_left;
    logic [23:0] ramp;
    logic [15:0] level;
    logic [11:0] alpha;
    blend_res_t  res;
    rows_left = 16'(exp_height) - 16'(row_pos);
    ramp      = exp_step * rows_left;
    level     = 16'(shade) + ramp[15:0];
    alpha     = level[15:4];
    res.we    = (alpha <= 12'd15);
    if (res.we) begin
      res.pix = {shade_channel(exp_color[11:8], dest[11:8], alpha[3:0]),
                 shade_channel(exp_color[7:4], dest[7:4], alpha[3:0]),
                 shade_channel(exp_color[3:0], dest[3:0], alpha[3:0])};
    end else begin
      res.pix = dest;
    end
    res.row_end    = (int'(col_pos) + 1 >= int'(exp_width)) || (col_pos == CoordLast);
    res.region_end = res.row_end &&
                     ((int'(row_pos) + 1 >= int'(exp_height)) || (row_pos == CoordLast));
    if (res.row_end) begin
      col_pos = '0;
      row_pos = res.region_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // register writes, input transfers and result transfers are all seen at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    blend_res_t got;
    blend_res_t want;
    if (!rst_ni) begin
      exp_width  = WidthReset;
      exp_height = HeightReset;
      exp_step   = StepReset;
      exp_color  = ColorReset;
      col_pos    = '0;
      row_pos    = '0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_WIDTH:  exp_width  = pwdata[SizeBits-1:0];
          REG_HEIGHT: exp_height = pwdata[SizeBits-1:0];
          REG_STEP:   exp_step   = pwdata[StepBits-1:0];
          REG_COLOR:  exp_color  = pwdata[PixBits-1:0];
          default:    ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(fade_blend_pixel(s_axis_tdata[7:0], s_axis_tdata[19:8]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.we         = m_axis_tuser[0];
        got.pix        = m_axis_tdata[PixBits-1:0];
        got.row_end    = m_axis_tlast;
        got.region_end = m_axis_tuser[1];
        if (expected_pixels.size() == 0) begin
          $error("result transfer with nothing pending: blended_pixel %h", got.pix);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("write_enable", want.we, got.we);
          check_field("blended_pixel", want.pix, got.pix);
          check_field("row_end", want.row_end, got.row_end);
          check_field("region_end", want.region_end, got.region_end);
        end
      end
    end
  end

  // all tasks below are entered and left at a rising edge
  task automatic send_pixel(input logic [ShadeBits-1:0] shade, input logic [PixBits-1:0] dest);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, dest, shade};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // lets the last input transfer reach the queue before waiting for it to empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  // junk above the register width must be dropped by the block
  task automatic cfg_write(input reg_idx_e idx, input int unsigned value);
    logic [DataBits-1:0] mask;
    mask = 32'hFFF;
    case (idx)
      REG_WIDTH, REG_HEIGHT: mask = 32'h7FF;
      REG_STEP:              mask = 32'hFF;
      REG_COLOR:             mask = 32'hFFF;
      default:               mask = 32'hFFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom() & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_region(input int unsigned width, input int unsigned height,
                            input int unsigned step, input int unsigned color);
    wait_drained();
    cfg_write(REG_WIDTH, width);
    cfg_write(REG_HEIGHT, height);
    cfg_write(REG_STEP, step);
    cfg_write(REG_COLOR, color);
  endtask

  task automatic send_random();
    send_pixel(8'($urandom_range(255)), 12'($urandom_range(4095)));
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(13, 64);
      2:       return $urandom_range(0, 2047);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(4))
      0:       return $urandom_range(0, 255);
      1:       return $urandom_range(0, 40);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic test_reset_values();
    // 640x480, no fade, black text: alpha is just the shade's upper nibble
    send_pixel(8'h00, 12'h000);
    send_pixel(8'hFF, 12'hFFF);
    send_pixel(8'hF0, 12'h5A3);
    send_pixel(8'h0F, 12'hFFF);
  endtask

  task automatic test_blend_extremes();
    set_region(4, 2, 0, 12'hFFF);
    send_pixel(8'h00, 12'h000);
    send_pixel(8'hFF, 12'h000);
    send_pixel(8'h80, 12'hFFF);
    send_pixel(8'h7F, 12'h000);
    // row 1 of 2: ramp 255, so shade 1 already pushes alpha past 15
    set_region(4, 2, 255, 12'h5AC);
    send_pixel(8'h00, 12'h123);
    send_pixel(8'h01, 12'hABC);
    send_pixel(8'hFF, 12'hFFF);
    send_pixel(8'h00, 12'h9E1);
  endtask

  task automatic test_degenerate_sizes();
    set_region(0, 0, 0, 12'hF0F);
    send_pixel(8'h3C, 12'h0F0);
    send_pixel(8'hC3, 12'hF0F);
    set_region(0, 3, 1, 12'h0F0);
    send_pixel(8'h10, 12'h777);
    send_pixel(8'hE0, 12'h888);
    set_region(3, 0, 2, 12'h321);
    repeat (3) send_random();
  endtask

  task automatic test_mid_region_resize();
    set_region(1, 8, 1, 12'hABC);
    repeat (6) send_random();
    // row 6 with height 2: rows left wraps to 65532, the ramp wraps too
    set_region(4, 2, 1, 12'hCBA);
    send_pixel(8'h04, 12'h456);
    send_pixel(8'hC8, 12'hFED);
    send_pixel(8'h00, 12'h135);
    send_pixel(8'hFF, 12'h864);
    set_region(8, 3, 0, 12'h0FF);
    repeat (4) send_random();
    // column 4 already past the new last column
    wait_drained();
    cfg_write(REG_WIDTH, 2);
    send_pixel(8'h55, 12'hAAA);
  endtask

  task automatic test_counter_limits();
    int unsigned gaps[4]   = '{0, 58, 0, 17};
    int unsigned stalls[4] = '{0, 0, 58, 17};
    // width beyond the 10-bit column counter: row and region end at column 1023
    set_region(1100, 1, 0, $urandom_range(4095));
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      repeat (256) send_random();
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    int unsigned gaps[4]   = '{0, 58, 0, 17};
    int unsigned stalls[4] = '{0, 0, 58, 17};
    int unsigned sent;
    int unsigned seg_len;
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      sent      = 0;
      while (sent < 20) begin
        // some segments keep the old setting and carry on mid-region
        if ($urandom_range(4) != 0) begin
          wait_drained();
          if ($urandom_range(3) != 0) cfg_write(REG_WIDTH, pick_size());
          if ($urandom_range(3) != 0) cfg_write(REG_HEIGHT, pick_size());
          if ($urandom_range(3) != 0) cfg_write(REG_STEP, pick_step());
          if ($urandom_range(3) != 0) cfg_write(REG_COLOR, $urandom_range(4095));
        end
        seg_len = $urandom_range(5, 20);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(199) == 0) wait_drained();
          send_random();
        end
        sent += seg_len;
      end
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_blend_extremes();
    test_degenerate_sizes();
    test_mid_region_resize();
    test_counter_limits();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
